FILE: sv/pidsat_pkg.sv
package pidsat_pkg;

    localparam int ValW      = 16;
    localparam int GainW     = 16;
    localparam int TimeW     = 32;
    localparam int DriveW    = 8;
    localparam int ErrW      = 17;
    localparam int IntegW    = 8;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 32;
    localparam int SatLimit  = 100;
    localparam int FracBits  = 8;

    localparam logic [GainW-1:0] GainReset     = 16'd128;
    localparam logic [TimeW-1:0] IntervalReset = '0;
    localparam logic [ValW-1:0]  SetpointReset = '0;

    typedef enum logic [CfgAddrW-1:0] {
        CFG_GAIN_P   = 3'd0,
        CFG_GAIN_I   = 3'd1,
        CFG_GAIN_D   = 3'd2,
        CFG_INTERVAL = 3'd3,
        CFG_SETPOINT = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic signed [GainW-1:0] gain_p;
        logic signed [GainW-1:0] gain_i;
        logic signed [GainW-1:0] gain_d;
        logic        [TimeW-1:0] update_interval;
        logic signed [ValW-1:0]  setpoint;
    } cfg_t;

endpackage

FILE: sv/pidsat_if.sv
interface pidsat_sample_if;
    import pidsat_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [ValW-1:0] measurement;
    logic [TimeW-1:0]       time_now;

    modport source (output valid, measurement, time_now, input ready);
    modport sink   (input valid, measurement, time_now, output ready);
endinterface

interface pidsat_result_if;
    import pidsat_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DriveW-1:0] drive;
    logic                     due;

    modport source (output valid, drive, due, input ready);
    modport sink   (input valid, drive, due, output ready);
endinterface

FILE: sv/pidsat_cfg.sv
module pidsat_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [pidsat_pkg::CfgAddrW-1:0] cfg_index,
    input  logic [pidsat_pkg::CfgDataW-1:0] cfg_wdata,
    output pidsat_pkg::cfg_t               cfg
);
    import pidsat_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_GAIN_P:   cfg_next.gain_p          = cfg_wdata[GainW-1:0];
                CFG_GAIN_I:   cfg_next.gain_i          = cfg_wdata[GainW-1:0];
                CFG_GAIN_D:   cfg_next.gain_d          = cfg_wdata[GainW-1:0];
                CFG_INTERVAL: cfg_next.update_interval = cfg_wdata[TimeW-1:0];
                CFG_SETPOINT: cfg_next.setpoint        = cfg_wdata[ValW-1:0];
                default:      cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p          <= GainReset;
            cfg_reg.gain_i          <= GainReset;
            cfg_reg.gain_d          <= GainReset;
            cfg_reg.update_interval <= IntervalReset;
            cfg_reg.setpoint        <= SetpointReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/pidsat_core.sv
module pidsat_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pidsat_pkg::cfg_t                    cfg,
    input  logic                                step_en,
    input  logic signed [pidsat_pkg::ValW-1:0]  measurement,
    input  logic [pidsat_pkg::TimeW-1:0]        time_now,
    output logic signed [pidsat_pkg::DriveW-1:0] drive,
    output logic                                due
);
    import pidsat_pkg::*;

    localparam int SumW   = ErrW + 1;
    localparam int PW     = GainW + ErrW;
    localparam int IW     = GainW + IntegW;
    localparam int DW     = GainW + SumW;
    localparam int AccW   = DW + 2;
    localparam int QuotW  = AccW - FracBits;

    localparam logic signed [SumW-1:0]  SumHi  = SumW'(SatLimit);
    localparam logic signed [SumW-1:0]  SumLo  = SumW'(-SatLimit);
    localparam logic signed [QuotW-1:0] QuotHi = QuotW'(SatLimit);
    localparam logic signed [QuotW-1:0] QuotLo = QuotW'(-SatLimit);
    localparam logic signed [AccW-1:0]  RoundBias = AccW'((1 << FracBits) - 1);

    logic signed [IntegW-1:0] integ_reg, integ_next;
    logic signed [ErrW-1:0]   prev_err_reg, prev_err_next;
    logic [TimeW-1:0]         last_time_reg, last_time_next;

    logic [TimeW-1:0]         elapsed;
    logic signed [ErrW-1:0]   err;
    logic signed [SumW-1:0]   integ_wide;
    logic signed [IntegW-1:0] integ_clamped;
    logic signed [SumW-1:0]   deriv;
    logic signed [PW-1:0]     p_prod;
    logic signed [IW-1:0]     i_prod;
    logic signed [DW-1:0]     d_prod;
    logic signed [AccW-1:0]   acc;
    logic signed [AccW-1:0]   acc_adj;
    logic signed [QuotW-1:0]  quot;
    logic signed [DriveW-1:0] drive_sat;

    assign elapsed = time_now - last_time_reg;
    assign due     = (elapsed >= cfg.update_interval);

    always_comb
    begin
        err        = {cfg.setpoint[ValW-1], cfg.setpoint} - {measurement[ValW-1], measurement};
        integ_wide = SumW'(integ_reg) + SumW'(err);
        if (integ_wide > SumHi)
            integ_clamped = IntegW'(SumHi);
        else if (integ_wide < SumLo)
            integ_clamped = IntegW'(SumLo);
        else
            integ_clamped = integ_wide[IntegW-1:0];

        deriv  = SumW'(err) - SumW'(prev_err_reg);
        p_prod = cfg.gain_p * err;
        i_prod = cfg.gain_i * integ_clamped;
        d_prod = cfg.gain_d * deriv;
        acc    = AccW'(p_prod) + AccW'(i_prod) + AccW'(d_prod);

        // arithmetic shift floors; bias negatives so the divide truncates toward zero
        acc_adj = acc[AccW-1] ? (acc + RoundBias) : acc;
        quot    = acc_adj[AccW-1:FracBits];

        if (quot > QuotHi)
            drive_sat = DriveW'(QuotHi);
        else if (quot < QuotLo)
            drive_sat = DriveW'(QuotLo);
        else
            drive_sat = quot[DriveW-1:0];
    end

    assign drive = due ? drive_sat : '0;

    always_comb
    begin
        integ_next     = integ_reg;
        prev_err_next  = prev_err_reg;
        last_time_next = last_time_reg;
        if (step_en && due)
        begin
            integ_next     = integ_clamped;
            prev_err_next  = err;
            last_time_next = time_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg     <= '0;
            prev_err_reg  <= '0;
            last_time_reg <= '0;
        end
        else
        begin
            integ_reg     <= integ_next;
            prev_err_reg  <= prev_err_next;
            last_time_reg <= last_time_next;
        end
    end

    a_integ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= IntegW'(SatLimit)) && (integ_reg >= IntegW'(-SatLimit)))
        else $error("integral left its clamp range");

    a_idle_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        !(step_en && due) |=> $stable(integ_reg) && $stable(prev_err_reg)
                              && $stable(last_time_reg))
        else $error("controller state changed without a due update");

    a_update_stamps_time: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && due) |=> last_time_reg == $past(time_now))
        else $error("update did not record its tick");

endmodule

FILE: sv/pid_controller_saturating_unit.sv
// PID controller with clamped integral and saturated output.
//
// Channels: "sample" takes one beat per control sample (measurement, time_now);
// "result" returns exactly one beat per sample (drive, due). Both use a
// valid/ready handshake; a beat moves on a clock edge with valid and ready high.
// Gains, update interval and setpoint are set through cfg_wen/cfg_index/cfg_wdata,
// one register per write. The user must write them only while the block holds no
// sample in flight; the block itself does not enforce this.
//
// A sample beat loads the input register; the single-pass PID datapath then feeds
// the result register. Throughput: one sample per cycle while result is not
// stalled. The controller state (integral, last error, last update tick) is
// updated when due, in the same edge that loads the result, so the next sample,
// already waiting in the input register, sees it at once.
//
// Reset: gains return to 0.5 (Q8.8), interval and setpoint to 0, state clears,
// both pipeline registers empty. When the receiver stalls, the result register
// holds; one more sample can sit in the input register, after which sample.ready
// drops until result is taken.
module pid_controller_saturating_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    pidsat_sample_if.sink                   sample,
    pidsat_result_if.source                 result,
    input  logic                            cfg_wen,
    input  logic [pidsat_pkg::CfgAddrW-1:0] cfg_index,
    input  logic [pidsat_pkg::CfgDataW-1:0] cfg_wdata
);
    import pidsat_pkg::*;

    cfg_t cfg;

    // input register
    logic                     in_valid_reg;
    logic signed [ValW-1:0]   meas_reg;
    logic [TimeW-1:0]         time_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [DriveW-1:0] drive_reg;
    logic                     due_reg;

    logic                     step_fire;
    logic                     sample_take;
    logic signed [DriveW-1:0] core_drive;
    logic                     core_due;

    // a sample advances when the result register is empty or being drained
    assign step_fire   = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || step_fire;
    assign sample_take = sample.valid && sample.ready;

    pidsat_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidsat_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .step_en     (step_fire),
        .measurement (meas_reg),
        .time_now    (time_reg),
        .drive       (core_drive),
        .due         (core_due)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_take)
                in_valid_reg <= 1'b1;
            else if (step_fire)
                in_valid_reg <= 1'b0;

            if (step_fire)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            meas_reg <= sample.measurement;
            time_reg <= sample.time_now;
        end
        if (step_fire)
        begin
            drive_reg <= core_drive;
            due_reg   <= core_due;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.drive = drive_reg;
    assign result.due   = due_reg;

    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (drive_reg <= DriveW'(SatLimit)) && (drive_reg >= DriveW'(-SatLimit)))
        else $error("drive outside saturation range");

    a_not_due_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !due_reg) |-> drive_reg == '0)
        else $error("drive nonzero on a skipped update");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> in_valid_reg && out_valid_reg && !result.ready)
        else $error("sample channel stalled with room in the pipeline");

    a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire |=> out_valid_reg)
        else $error("processed sample produced no result beat");

endmodule
